// ===== src/tbi_pkg.sv =====
// Shared constants and types for the triangle barycentric interpolator.
// Used by the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tbi_pkg;

  localparam int DIR_W           = 16;  // direction fields, Q1.14
  localparam int DIR_FRAC        = 14;
  localparam int COORD_FRAC      = 4;   // coordinates and values, Q12.4
  localparam int WEIGHT_INT_BITS = 4;   // weight integer bits incl. sign

  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [OP_W-1:0] OP_WEIGHTS = 2'd0;
  localparam logic [OP_W-1:0] OP_SCALAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_VECTOR  = 2'd2;
  localparam logic [OP_W-1:0] OP_DERIV   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_V0X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_V0Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_V1X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_V1Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_V2X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_V2Y = 3'd5;

  // Per-item flags that ride beside the divider stages.
  // neg: weight0..weight2, result_x, result_y
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            sing;
    logic [4:0]      neg;
  } tbi_side_t;

endpackage

`default_nettype wire

// ===== src/tbi_div.sv =====
// Pipelined restoring divider on magnitudes: one quotient bit per stage.
// Stage 0 checks quotient overflow; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module tbi_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 35,
  parameter int Q_W   = 22
) (
  input  wire logic             clk,
  input  wire logic [Q_W:0]     adv,   // load enable per stage
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [Q_W-1:0]   quo,   // floor(num / den) when !over
  output logic                  over   // quotient does not fit in Q_W bits
);

  localparam int HI_W  = NUM_W - Q_W;
  localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

  logic [DEN_W-1:0] rem [Q_W+1];
  logic [Q_W-1:0]   low [Q_W+1];
  logic [Q_W-1:0]   qb  [Q_W+1];
  logic [DEN_W-1:0] dv  [Q_W+1];
  logic             ov  [Q_W+1];
  logic [DEN_W:0]   trial [Q_W+1];
  logic             take  [Q_W+1];
  logic [HI_W-1:0]  hi;

  assign hi = num[NUM_W-1:Q_W];

  always_comb begin
    trial[0] = '0;
    take[0]  = 1'b0;
    for (int k = 1; k <= Q_W; k++) begin
      trial[k] = {rem[k-1], low[k-1][Q_W-1]};
      take[k]  = trial[k] >= {1'b0, dv[k-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ov[0]  <= CMP_W'(hi) >= CMP_W'(den);
      rem[0] <= DEN_W'(hi);
      low[0] <= num[Q_W-1:0];
      qb[0]  <= '0;
      dv[0]  <= den;
    end
    for (int k = 1; k <= Q_W; k++) begin
      if (adv[k]) begin
        if (take[k]) begin
          rem[k] <= DEN_W'(trial[k] - {1'b0, dv[k-1]});
        end else begin
          rem[k] <= trial[k][DEN_W-1:0];
        end
        qb[k]  <= {qb[k-1][Q_W-2:0], take[k]};
        low[k] <= {low[k-1][Q_W-2:0], 1'b0};
        dv[k]  <= dv[k-1];
        ov[k]  <= ov[k-1];
      end
    end
  end

  assign quo  = qb[Q_W];
  assign over = ov[Q_W];

endmodule

`default_nettype wire

// ===== src/triangle_barycentric_interpolator_unit.sv =====
// Triangle barycentric interpolator top level: front-end arithmetic pipeline,
// five tbi_div dividers and output rounding. Depends on tbi_pkg and tbi_div.
`timescale 1ns / 1ps
`default_nettype none

// Takes one item per clock while the output is not stalled and returns one
// item per item, in order. The pipeline is COORD_WIDTH-independent front work
// (5 stages) plus the divider chain (QW+1 stages, QW = max(weight width,
// COORD_WIDTH) + 2) plus one output register. The divider chain, one
// quotient bit per stage, sets the depth. Stalls on the output back up
// stage by stage; empty stages still take new items.
module triangle_barycentric_interpolator_unit #(
  parameter int COORD_WIDTH      = 16,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // point_x, point_y, value0_x, value0_y, value1_x, value1_y, value2_x,
  // value2_y, dir_x, dir_y
  input  wire logic [((8*COORD_WIDTH+2*tbi_pkg::DIR_W+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic [tbi_pkg::OP_W-1:0] s_axis_tuser,  // operation
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // weight0, weight1, weight2, result_x, result_y
  output logic [((3*(WEIGHT_FRAC_BITS+tbi_pkg::WEIGHT_INT_BITS)+2*COORD_WIDTH+7)/8)*8-1:0]
               m_axis_tdata,
  output logic m_axis_tuser,  // singular
  input  wire logic                            cfg_we,
  input  wire logic [tbi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [COORD_WIDTH-1:0]          cfg_data
);

  import tbi_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int WF    = WEIGHT_FRAC_BITS;
  localparam int WW    = WF + WEIGHT_INT_BITS;
  localparam int DW    = CW + 1;
  localparam int NW    = (2*CW+3 > DIR_W+CW+3) ? 2*CW+3 : DIR_W+CW+3;
  localparam int SW    = CW + NW + 2;
  localparam int SH_D  = WF + DIR_FRAC - COORD_FRAC;
  localparam int WN_W  = NW + SH_D + 1;
  localparam int RN_W  = SW + 1;
  localparam int QW    = ((WW > CW) ? WW : CW) + 2;
  localparam int FS    = 5;
  localparam int P     = FS + QW + 2;
  localparam int OUT_W = ((3*WW+2*CW+7)/8)*8;
  localparam int NXT[3] = '{1, 2, 0};
  localparam int PRV[3] = '{2, 0, 1};
  localparam logic [QW:0] CAP_W = (QW+1)'(1) << (WW-1);
  localparam logic [QW:0] CAP_R = (QW+1)'(1) << (CW-1);
  localparam logic [CW-1:0] ONE = CW'(1) << COORD_FRAC;

  // vertex registers
  logic signed [CW-1:0] vx [3];
  logic signed [CW-1:0] vy [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vx[0] <= '0;  vy[0] <= '0;
      vx[1] <= ONE; vy[1] <= '0;
      vx[2] <= '0;  vy[2] <= ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_V0X: vx[0] <= cfg_data;
        REG_V0Y: vy[0] <= cfg_data;
        REG_V1X: vx[1] <= cfg_data;
        REG_V1Y: vy[1] <= cfg_data;
        REG_V2X: vx[2] <= cfg_data;
        REG_V2Y: vy[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage handshake
  logic [P-1:0] v;
  logic [P:0]   adv;

  always_comb begin
    adv[P] = m_axis_tready;
    for (int i = P-1; i >= 0; i--) begin
      adv[i] = ~v[i] | adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < P; i++) begin
        if (adv[i]) begin
          v[i] <= (i == 0) ? s_axis_tvalid : v[(i == 0) ? 0 : i-1];
        end
      end
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = v[P-1];

  // input unpack
  logic signed [CW-1:0]    in_px, in_py;
  logic signed [CW-1:0]    in_val [6];
  logic signed [DIR_W-1:0] in_ex, in_ey;

  always_comb begin
    in_px = s_axis_tdata[CW-1:0];
    in_py = s_axis_tdata[2*CW-1:CW];
    for (int j = 0; j < 6; j++) begin
      in_val[j] = s_axis_tdata[(2+j)*CW +: CW];
    end
    in_ex = s_axis_tdata[8*CW +: DIR_W];
    in_ey = s_axis_tdata[8*CW+DIR_W +: DIR_W];
  end

  // stage 1: differences
  logic [OP_W-1:0]         s1_op;
  logic signed [CW-1:0]    s1_px, s1_py;
  logic signed [CW-1:0]    s1_val [6];
  logic signed [DIR_W-1:0] s1_ex, s1_ey;
  logic signed [DW-1:0]    s1_a [3];
  logic signed [DW-1:0]    s1_b [3];
  logic signed [DW-1:0]    s1_dpx2, s1_dpy2, s1_dpx1, s1_dpy1;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_op  <= s_axis_tuser;
      s1_px  <= in_px;
      s1_py  <= in_py;
      s1_val <= in_val;
      s1_ex  <= in_ex;
      s1_ey  <= in_ey;
      for (int i = 0; i < 3; i++) begin
        s1_a[i] <= DW'(vy[NXT[i]]) - DW'(vy[PRV[i]]);
        s1_b[i] <= DW'(vx[PRV[i]]) - DW'(vx[NXT[i]]);
      end
      s1_dpx2 <= DW'(in_px) - DW'(vx[2]);
      s1_dpy2 <= DW'(in_py) - DW'(vy[2]);
      s1_dpx1 <= DW'(in_px) - DW'(vx[1]);
      s1_dpy1 <= DW'(in_py) - DW'(vy[1]);
    end
  end

  // stage 2: products
  logic [OP_W-1:0]      s2_op;
  logic signed [CW-1:0] s2_val [6];
  logic signed [NW-1:0] s2_pa [3];
  logic signed [NW-1:0] s2_pb [3];
  logic signed [NW-1:0] s2_c  [3];
  logic signed [NW-1:0] s2_cc [3];
  logic signed [NW-1:0] s2_dt [3];
  logic signed [NW-1:0] s2_e  [6];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_op  <= s1_op;
      s2_val <= s1_val;
      for (int i = 0; i < 3; i++) begin
        s2_pa[i] <= NW'(s1_a[i]) * NW'(s1_px);
        s2_pb[i] <= NW'(s1_b[i]) * NW'(s1_py);
        s2_c[i]  <= NW'(vx[NXT[i]]) * NW'(vy[PRV[i]]);
        s2_cc[i] <= NW'(vx[PRV[i]]) * NW'(vy[NXT[i]]);
        s2_dt[i] <= NW'(vx[i]) * NW'(s1_a[i]);
      end
      s2_e[0] <= NW'(s1_ex) * NW'(s1_dpy2);
      s2_e[1] <= NW'(s1_ey) * NW'(s1_dpx2);
      s2_e[2] <= NW'(s1_ey) * NW'(s1_dpx1);
      s2_e[3] <= NW'(s1_ex) * NW'(s1_dpy1);
      s2_e[4] <= NW'(s1_ex) * NW'(s1_a[0]);
      s2_e[5] <= NW'(s1_ey) * NW'(s1_b[0]);
    end
  end

  // stage 3: numerators and determinant
  logic [OP_W-1:0]      s3_op;
  logic signed [CW-1:0] s3_val [6];
  logic signed [NW-1:0] s3_n [3];
  logic signed [NW-1:0] s3_det;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_op   <= s2_op;
      s3_val  <= s2_val;
      s3_n[0] <= s2_pa[0] + s2_pb[0] + s2_c[0] - s2_cc[0];
      if (s2_op == OP_DERIV) begin
        s3_n[1] <= s2_e[0] - s2_e[1];
        s3_n[2] <= s2_e[2] - s2_e[3];
        s3_det  <= s2_e[4] + s2_e[5];
      end else begin
        s3_n[1] <= s2_pa[1] + s2_pb[1] + s2_c[1] - s2_cc[1];
        s3_n[2] <= s2_pa[2] + s2_pb[2] + s2_c[2] - s2_cc[2];
        s3_det  <= s2_dt[0] + s2_dt[1] + s2_dt[2];
      end
    end
  end

  // stage 4: value products
  logic [OP_W-1:0]      s4_op;
  logic signed [NW-1:0] s4_n [3];
  logic signed [NW-1:0] s4_det;
  logic signed [SW-1:0] s4_pv [6];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_op  <= s3_op;
      s4_n   <= s3_n;
      s4_det <= s3_det;
      for (int i = 0; i < 3; i++) begin
        for (int c = 0; c < 2; c++) begin
          s4_pv[2*i+c] <= SW'(s3_val[2*i+c]) * SW'(s3_n[i]);
        end
      end
    end
  end

  // stage 5: sums, magnitudes, signs, scaled dividends
  logic signed [SW-1:0] sum_x, sum_y;
  logic [NW-1:0]        mag_n [3];
  logic [NW-1:0]        mag_d;
  logic [SW-1:0]        mag_x, mag_y;
  logic                 det_neg;

  always_comb begin
    sum_x   = s4_pv[0] + s4_pv[2] + s4_pv[4];
    sum_y   = s4_pv[1] + s4_pv[3] + s4_pv[5];
    det_neg = s4_det[NW-1];
    for (int i = 0; i < 3; i++) begin
      mag_n[i] = s4_n[i][NW-1] ? NW'(-s4_n[i]) : NW'(s4_n[i]);
    end
    mag_d = det_neg ? NW'(-s4_det) : NW'(s4_det);
    mag_x = sum_x[SW-1] ? SW'(-sum_x) : SW'(sum_x);
    mag_y = sum_y[SW-1] ? SW'(-sum_y) : SW'(sum_y);
  end

  logic [WN_W-1:0] s5_wnum [3];
  logic [RN_W-1:0] s5_rnum [2];
  logic [NW-1:0]   s5_den;
  tbi_side_t       s5_side;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      // dividend carries one extra bit so the last quotient bit gives rounding
      if (s4_op == OP_DERIV) begin
        s5_wnum[0] <= WN_W'(mag_n[0]) << (SH_D + 1);
      end else begin
        s5_wnum[0] <= WN_W'(mag_n[0]) << (WF + 1);
      end
      s5_wnum[1]   <= WN_W'(mag_n[1]) << (WF + 1);
      s5_wnum[2]   <= WN_W'(mag_n[2]) << (WF + 1);
      s5_rnum[0]   <= RN_W'(mag_x) << 1;
      s5_rnum[1]   <= RN_W'(mag_y) << 1;
      s5_den       <= mag_d;
      s5_side.op   <= s4_op;
      s5_side.sing <= (s4_det == '0);
      s5_side.neg  <= {sum_y[SW-1] ^ det_neg, sum_x[SW-1] ^ det_neg,
                       s4_n[2][NW-1] ^ det_neg, s4_n[1][NW-1] ^ det_neg,
                       s4_n[0][NW-1] ^ det_neg};
    end
  end

  // dividers
  logic [QW-1:0] wq [3];
  logic          wo [3];
  logic [QW-1:0] rq [2];
  logic          ro [2];

  for (genvar g = 0; g < 3; g++) begin : g_wdiv
    tbi_div #(.NUM_W(WN_W), .DEN_W(NW), .Q_W(QW)) u_div (
      .clk  (clk),
      .adv  (adv[FS+QW:FS]),
      .num  (s5_wnum[g]),
      .den  (s5_den),
      .quo  (wq[g]),
      .over (wo[g])
    );
  end

  for (genvar g = 0; g < 2; g++) begin : g_rdiv
    tbi_div #(.NUM_W(RN_W), .DEN_W(NW), .Q_W(QW)) u_div (
      .clk  (clk),
      .adv  (adv[FS+QW:FS]),
      .num  (s5_rnum[g]),
      .den  (s5_den),
      .quo  (rq[g]),
      .over (ro[g])
    );
  end

  tbi_side_t sb [QW+1];

  always_ff @(posedge clk) begin
    if (adv[FS]) begin
      sb[0] <= s5_side;
    end
    for (int k = 1; k <= QW; k++) begin
      if (adv[FS+k]) begin
        sb[k] <= sb[k-1];
      end
    end
  end

  // round half away from zero, then saturate
  function automatic logic [WW-1:0] sat_w(input logic [QW-1:0] q, input logic ov,
                                          input logic neg);
    logic [QW:0] r;
    r = ({1'b0, q} + (QW+1)'(1)) >> 1;
    if (ov || r > CAP_W) r = CAP_W;
    if (neg) r = -r;
    else if (r > CAP_W - (QW+1)'(1)) r = CAP_W - (QW+1)'(1);
    return r[WW-1:0];
  endfunction

  function automatic logic [CW-1:0] sat_r(input logic [QW-1:0] q, input logic ov,
                                          input logic neg);
    logic [QW:0] r;
    r = ({1'b0, q} + (QW+1)'(1)) >> 1;
    if (ov || r > CAP_R) r = CAP_R;
    if (neg) r = -r;
    else if (r > CAP_R - (QW+1)'(1)) r = CAP_R - (QW+1)'(1);
    return r[CW-1:0];
  endfunction

  // output register
  logic [WW-1:0] o_w [3];
  logic [CW-1:0] o_rx, o_ry;
  logic          o_sing;
  tbi_side_t     last;

  assign last = sb[QW];

  always_ff @(posedge clk) begin
    if (adv[P-1]) begin
      o_sing <= last.sing;
      for (int i = 0; i < 3; i++) begin
        o_w[i] <= last.sing ? '0 : sat_w(wq[i], wo[i], last.neg[i]);
      end
      if (last.sing || !(last.op == OP_SCALAR || last.op == OP_VECTOR)) begin
        o_rx <= '0;
      end else begin
        o_rx <= sat_r(rq[0], ro[0], last.neg[3]);
      end
      if (last.sing || last.op != OP_VECTOR) begin
        o_ry <= '0;
      end else begin
        o_ry <= sat_r(rq[1], ro[1], last.neg[4]);
      end
    end
  end

  assign m_axis_tdata = OUT_W'({o_ry, o_rx, o_w[2], o_w[1], o_w[0]});
  assign m_axis_tuser = o_sing;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("singular item with nonzero payload");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("output item changed while stalled");

endmodule

`default_nettype wire
